// ===== rtl/core/ter_pkg.sv =====
// Shared constants, types and codes of the trace event ring recorder.
`default_nettype none
package ter_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int TASK_SLOTS = 32;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int TBL_IW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int TBL_CW  = $clog2(TASK_SLOTS + 1);

    typedef enum logic [1:0] {
        REQ_LOG = 2'd0,
        REQ_POP = 2'd1,
        REQ_REG = 2'd2
    } t_req_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [31:0] timestamp;
        logic [15:0] code;
        logic        core;
        logic [7:0]  prio;
        logic [31:0] tid;
        logic [31:0] aux;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Lookup and append commands for the task table.
    typedef struct packed {
        logic        lookup_en;
        logic [31:0] lookup_handle;
        logic        wr_en;
        logic [31:0] wr_handle;
        logic [31:0] wr_id;
    } t_tbl_req;

endpackage
`default_nettype wire

// ===== rtl/core/ter_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ter_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ter_task_table.sv =====
// Registered-task table: parallel first-match lookup and append.
`default_nettype none
module ter_task_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ter_pkg::t_tbl_req i_req,
    output logic                   o_full,
    output logic [31:0]            o_tid
);
    import ter_pkg::*;

    logic [31:0]       r_handle [TASK_SLOTS];
    logic [31:0]       r_id     [TASK_SLOTS];
    logic [TBL_CW-1:0] r_count;
    logic [TBL_CW-1:0] n_count;
    logic [31:0]       r_tid;
    logic [31:0]       n_tid;

    assign o_full = (r_count == TBL_CW'(TASK_SLOTS));
    assign o_tid  = r_tid;

    // Walking from the top down leaves the lowest matching slot in n_tid.
    always_comb begin
        n_tid = '0;
        for (int k = TASK_SLOTS - 1; k >= 0; k--) begin
            if ((TBL_CW'(k) < r_count) && (r_handle[k] == i_req.lookup_handle)) begin
                n_tid = r_id[k];
            end
        end
    end

    assign n_count = r_count + TBL_CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_req.wr_en && !o_full) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && !o_full) begin
            r_handle[r_count[TBL_IW-1:0]] <= i_req.wr_handle;
            r_id[r_count[TBL_IW-1:0]]     <= i_req.wr_id;
        end
        if (i_req.lookup_en) begin
            r_tid <= n_tid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/trace_event_ring_recorder.sv =====
// Top level of the trace event ring recorder: request sequencing, ring pointers and result register.
`default_nettype none
// A request is accepted in ST_IDLE, where the ring memory read at the read
// pointer and the task-table lookup are issued, and then executes in ST_EXEC,
// where it writes the ring or the table and loads the result register. The
// ring memory read is registered. A request waits in ST_EXEC only while the
// previous result still sits untaken in the result register. A new request can
// be accepted while a result waits. The ring holds up to RING_DEPTH-1 records,
// logs into a full ring are counted as drops, and no clearing pass runs after
// reset.
module trace_event_ring_recorder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_task_handle,
    input  wire logic [15:0] i_event_code,
    input  wire logic [31:0] i_aux_word,
    input  wire logic [31:0] i_timestamp_us,
    input  wire logic        i_core_id,
    input  wire logic [7:0]  i_task_priority,
    input  wire logic [31:0] i_reg_task_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_accepted,
    output logic [31:0]      o_out_timestamp,
    output logic [15:0]      o_out_event_code,
    output logic             o_out_core,
    output logic [7:0]       o_out_priority,
    output logic [31:0]      o_out_task_id,
    output logic [31:0]      o_out_aux,
    output logic [31:0]      o_drop_count
);
    import ter_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic               in_fire;
    logic               exec_fire;

    logic [1:0]         r_kind;
    logic [31:0]        r_handle;
    logic [15:0]        r_code;
    logic [31:0]        r_aux;
    logic [31:0]        r_time;
    logic               r_core;
    logic [7:0]         r_prio;
    logic [31:0]        r_rid;

    logic [RING_AW-1:0] r_wr_ptr;
    logic [RING_AW-1:0] n_wr_ptr;
    logic [RING_AW-1:0] r_rd_ptr;
    logic [RING_AW-1:0] n_rd_ptr;
    logic [RING_AW-1:0] wr_next;
    logic [RING_AW-1:0] rd_next;
    logic [31:0]        r_drops;
    logic [31:0]        n_drops;

    logic               ram_wr_en;
    t_rec               ram_wr_rec;
    t_rec               ram_rd_rec;

    t_tbl_req           tbl_req;
    logic               tbl_full;
    logic [31:0]        tbl_tid;
    logic               tbl_wr;

    logic               r_out_valid;
    logic               n_out_valid;
    logic               n_accepted;
    t_rec               n_out_rec;
    t_rec               r_out_rec;
    logic               r_accepted;

    assign in_fire = i_in_valid && o_in_ready;

    // Sequencer: one request in flight, executed once the result register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        exec_fire  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    exec_fire = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind   <= i_req_type;
            r_handle <= i_task_handle;
            r_code   <= i_event_code;
            r_aux    <= i_aux_word;
            r_time   <= i_timestamp_us;
            r_core   <= i_core_id;
            r_prio   <= i_task_priority;
            r_rid    <= i_reg_task_id;
        end
    end

    assign wr_next = (r_wr_ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : r_wr_ptr + RING_AW'(1);
    assign rd_next = (r_rd_ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : r_rd_ptr + RING_AW'(1);

    // Execution of the held request.
    always_comb begin
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_drops    = r_drops;
        ram_wr_en  = 1'b0;
        tbl_wr     = 1'b0;
        n_accepted = 1'b0;
        n_out_rec  = '0;

        ram_wr_rec.timestamp = r_time;
        ram_wr_rec.code      = r_code;
        ram_wr_rec.core      = r_core;
        ram_wr_rec.prio      = (r_handle == 32'd0) ? 8'd0 : r_prio;
        ram_wr_rec.tid       = tbl_tid;
        ram_wr_rec.aux       = r_aux;

        case (r_kind)
            REQ_LOG: begin
                if (wr_next == r_rd_ptr) begin
                    n_drops = r_drops + 32'd1;
                end else begin
                    ram_wr_en  = exec_fire;
                    n_wr_ptr   = wr_next;
                    n_accepted = 1'b1;
                end
            end
            REQ_POP: begin
                if (r_rd_ptr != r_wr_ptr) begin
                    n_out_rec  = ram_rd_rec;
                    n_rd_ptr   = rd_next;
                    n_accepted = 1'b1;
                end
            end
            REQ_REG: begin
                if ((r_handle != 32'd0) && !tbl_full) begin
                    tbl_wr     = exec_fire;
                    n_accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_drops  <= '0;
        end else if (exec_fire) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_drops  <= n_drops;
        end
    end

    // Reads are issued only in the accept cycle and writes only during execution,
    // so the two never touch the ring in the same cycle.
    ter_ram #(
        .WIDTH (REC_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (ram_wr_rec),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (ram_rd_rec)
    );

    always_comb begin
        tbl_req.lookup_en     = in_fire;
        tbl_req.lookup_handle = i_task_handle;
        tbl_req.wr_en         = tbl_wr;
        tbl_req.wr_handle     = r_handle;
        tbl_req.wr_id         = r_rid;
    end

    ter_task_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_full  (tbl_full),
        .o_tid   (tbl_tid)
    );

    // Result register.
    assign n_out_valid = exec_fire ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_accepted <= n_accepted;
            r_out_rec  <= n_out_rec;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_out_timestamp  = r_out_rec.timestamp;
    assign o_out_event_code = r_out_rec.code;
    assign o_out_core       = r_out_rec.core;
    assign o_out_priority   = r_out_rec.prio;
    assign o_out_task_id    = r_out_rec.tid;
    assign o_out_aux        = r_out_rec.aux;
    assign o_drop_count     = r_drops;

    // The drop counter moves only when a log request executes.
    a_drops_only_on_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_drops != $past(r_drops)))
            |-> ($past(exec_fire) && ($past(r_kind) == REQ_LOG)))
        else $error("drop counter changed outside a log transaction");

    // Both ring pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= RING_AW'(RING_DEPTH - 1)) && (r_rd_ptr <= RING_AW'(RING_DEPTH - 1)))
        else $error("ring pointer out of range");

    // A result appears only right after a request has executed.
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_out_valid)) |-> $past(exec_fire))
        else $error("result without an executed transaction");

    // A ring write never fills the ring: the advanced write pointer never reaches the read pointer.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (wr_next != r_rd_ptr))
        else $error("ring write into a full ring");

endmodule
`default_nettype wire

// ===== tb/trace_event_ring_recorder_tb.sv =====
// Self-checking testbench for the trace event ring recorder: directed rows and random traffic.
`default_nettype none
module trace_event_ring_recorder_tb;
    import ter_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] handle;
        logic [15:0] code;
        logic [31:0] aux;
        logic [31:0] tstamp;
        logic        core;
        logic [7:0]  prio;
        logic [31:0] reg_id;
    } t_req;

    typedef struct packed {
        logic        acc;
        t_rec        rec;
        logic [31:0] drops;
    } t_resp;

    typedef struct {
        t_req req;
        bit   typed;
        logic typed_acc;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_task_handle = '0;
    logic [15:0] i_event_code = '0;
    logic [31:0] i_aux_word = '0;
    logic [31:0] i_timestamp_us = '0;
    logic        i_core_id = 1'b0;
    logic [7:0]  i_task_priority = '0;
    logic [31:0] i_reg_task_id = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_accepted;
    logic [31:0] o_out_timestamp;
    logic [15:0] o_out_event_code;
    logic        o_out_core;
    logic [7:0]  o_out_priority;
    logic [31:0] o_out_task_id;
    logic [31:0] o_out_aux;
    logic [31:0] o_drop_count;

    // Shadow state of the recorder.
    t_rec        ring_fifo[$];
    logic [31:0] task_handles[$];
    logic [31:0] task_ids[$];
    logic [31:0] drop_total = '0;

    t_resp       pending_results[$];
    t_row        directed_rows[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off_req = 1'b0;
    int          hold_left = 0;

    trace_event_ring_recorder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_task_handle    (i_task_handle),
        .i_event_code     (i_event_code),
        .i_aux_word       (i_aux_word),
        .i_timestamp_us   (i_timestamp_us),
        .i_core_id        (i_core_id),
        .i_task_priority  (i_task_priority),
        .i_reg_task_id    (i_reg_task_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_accepted       (o_accepted),
        .o_out_timestamp  (o_out_timestamp),
        .o_out_event_code (o_out_event_code),
        .o_out_core       (o_out_core),
        .o_out_priority   (o_out_priority),
        .o_out_task_id    (o_out_task_id),
        .o_out_aux        (o_out_aux),
        .o_drop_count     (o_drop_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_resp compute_response(input t_req r);
        t_resp res;
        t_rec  rec;
        bit    hit;
        res = '0;
        rec = '0;
        hit = 1'b0;
        case (r.kind)
            REQ_LOG: begin
                if (ring_fifo.size() == RING_DEPTH - 1) begin
                    drop_total = drop_total + 32'd1;
                end else begin
                    rec.timestamp = r.tstamp;
                    rec.code      = r.code;
                    rec.core      = r.core;
                    rec.prio      = (r.handle == 32'd0) ? 8'd0 : r.prio;
                    rec.aux       = r.aux;
                    // The earliest registration of a handle wins.
                    for (int k = 0; k < task_handles.size(); k++) begin
                        if (!hit && task_handles[k] == r.handle) begin
                            rec.tid = task_ids[k];
                            hit = 1'b1;
                        end
                    end
                    ring_fifo.push_back(rec);
                    res.acc = 1'b1;
                end
            end
            REQ_POP: begin
                if (ring_fifo.size() != 0) begin
                    res.acc = 1'b1;
                    res.rec = ring_fifo.pop_front();
                end
            end
            REQ_REG: begin
                if (r.handle != 32'd0 && task_handles.size() < TASK_SLOTS) begin
                    task_handles.push_back(r.handle);
                    task_ids.push_back(r.reg_id);
                    res.acc = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.drops = drop_total;
        return res;
    endfunction

    function automatic logic [31:0] pick_handle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 32'd0;
        if (sel < 55 && task_handles.size() != 0)
            return task_handles[$urandom_range(task_handles.size() - 1)];
        if (sel < 60)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   sel;
        sel = $urandom_range(99);
        if (sel < 42)
            r.kind = REQ_LOG;
        else if (sel < 82)
            r.kind = REQ_POP;
        else if (sel < 95)
            r.kind = REQ_REG;
        else
            r.kind = REQ_UNUSED;
        r.handle = pick_handle();
        r.code   = 16'($urandom);
        r.aux    = $urandom;
        r.tstamp = $urandom;
        r.core   = 1'($urandom_range(1));
        r.prio   = 8'($urandom);
        r.reg_id = $urandom;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [31:0] handle,
                           input logic [15:0] code, input logic [31:0] aux,
                           input logic [31:0] tstamp, input logic core,
                           input logic [7:0] prio, input logic [31:0] reg_id,
                           input bit typed, input logic typed_acc);
        t_row row;
        row.req = '{kind, handle, code, aux, tstamp, core, prio, reg_id};
        row.typed = typed;
        row.typed_acc = typed_acc;
        directed_rows.push_back(row);
    endtask

    // Offers one transaction and records its expected response once accepted.
    task automatic offer(input t_req r, input bit typed, input logic typed_acc);
        t_resp pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= r.kind;
        i_task_handle   <= r.handle;
        i_event_code    <= r.code;
        i_aux_word      <= r.aux;
        i_timestamp_us  <= r.tstamp;
        i_core_id       <= r.core;
        i_task_priority <= r.prio;
        i_reg_task_id   <= r.reg_id;
        do @(posedge i_clk); while (!o_in_ready);
        pred = compute_response(r);
        if (typed) begin
            // Typed rows never pop a record and come before any drop.
            pred = '0;
            pred.acc = typed_acc;
        end
        pending_results.push_back(pred);
    endtask

    task automatic run_random(input int count);
        repeat (count) offer(random_req(), 1'b0, 1'b0);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_response();
        t_resp want;
        if (pending_results.size() == 0) begin
            $display("%0t: response with no transaction outstanding, expected none, actual %h",
                     $time, o_drop_count);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            compare_field("accepted", 32'(want.acc), 32'(o_accepted));
            compare_field("timestamp", want.rec.timestamp, o_out_timestamp);
            compare_field("event_code", 32'(want.rec.code), 32'(o_out_event_code));
            compare_field("core", 32'(want.rec.core), 32'(o_out_core));
            compare_field("priority", 32'(want.rec.prio), 32'(o_out_priority));
            compare_field("task_id", want.rec.tid, o_out_task_id);
            compare_field("aux", want.rec.aux, o_out_aux);
            compare_field("drop_count", want.drops, o_drop_count);
        end
    endtask

    // Response side: checks every response and drives the ready pattern.
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                check_response();
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        // Empty ring, unused kind, rejected registration.
        add_row(REQ_POP, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0, 1'b1, 1'b0);
        add_row(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_row(REQ_REG, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // A log without a task records priority zero.
        add_row(REQ_LOG, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 8'hFF, 32'd0, 1'b1, 1'b1);
        add_row(REQ_REG, 32'hFFFF_FFFF, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'hFFFF_FFFF,
                1'b1, 1'b1);
        add_row(REQ_REG, 32'd1, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'h0000_AAAA, 1'b1, 1'b1);
        // Same handle again: stored, but the first entry keeps winning the lookup.
        add_row(REQ_REG, 32'd1, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'h0000_5555, 1'b1, 1'b1);
        add_row(REQ_LOG, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF,
                32'd0, 1'b1, 1'b1);
        add_row(REQ_LOG, 32'hFFFF_FFFF, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0, 1'b1, 1'b1);
        add_row(REQ_LOG, 32'h1234_5678, 16'hA5C3, 32'h8000_0001, 32'h7FFF_FFFE, 1'b1,
                8'h80, 32'd0, 1'b1, 1'b1);
        add_row(REQ_POP, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0);
        add_row(REQ_POP, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0);
        add_row(REQ_POP, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0);
        add_row(REQ_POP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_row(REQ_POP, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0, 1'b1, 1'b0);
        add_row(REQ_UNUSED, 32'd1, 16'h1234, 32'd5, 32'd6, 1'b0, 8'd7, 32'd8, 1'b1, 1'b0);

        send_idle_pct = 10;
        recv_idle_pct = 63;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[idx])
            offer(directed_rows[idx].req, directed_rows[idx].typed,
                  directed_rows[idx].typed_acc);
        wait_drained();

        run_random(100);
        // Long receiver stall while transactions keep coming, so the input backs up.
        hold_off_req = 1'b1;
        run_random(120);
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 10;
        run_random(220);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(210);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
